### hw/rtl/tepf_pkg.sv
package tepf_pkg;

  localparam int unsigned NUM_TESTS = 18;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_AB   = 2'd1,
    CLS_BC   = 2'd2,
    CLS_CA   = 2'd3
  } edge_cls_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // corner selects of one shared-edge test: j[s1]==i[n1], j[s2]==i[n2], j[d]!=i[m]
  typedef struct packed {
    logic [1:0] s1;
    logic [1:0] n1;
    logic [1:0] s2;
    logic [1:0] n2;
    logic [1:0] d;
    logic [1:0] m;
    edge_cls_t  cls;
  } edge_test_t;

  function automatic edge_test_t test_of(input logic [4:0] k);
    edge_test_t r;
    case (k)
      5'd0:  r = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, CLS_AB};
      5'd1:  r = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd2, CLS_AB};
      5'd2:  r = '{2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd2, CLS_AB};
      5'd3:  r = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, CLS_AB};
      5'd4:  r = '{2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2, CLS_AB};
      5'd5:  r = '{2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, CLS_AB};
      5'd6:  r = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0, CLS_BC};
      5'd7:  r = '{2'd0, 2'd2, 2'd1, 2'd1, 2'd2, 2'd0, CLS_BC};
      5'd8:  r = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, CLS_BC};
      5'd9:  r = '{2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, CLS_BC};
      5'd10: r = '{2'd1, 2'd1, 2'd2, 2'd2, 2'd0, 2'd0, CLS_BC};
      5'd11: r = '{2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, CLS_BC};
      5'd12: r = '{2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, CLS_CA};
      5'd13: r = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, CLS_CA};
      5'd14: r = '{2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd1, CLS_CA};
      5'd15: r = '{2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1, CLS_CA};
      5'd16: r = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1, CLS_CA};
      5'd17: r = '{2'd1, 2'd0, 2'd2, 2'd2, 2'd0, 2'd1, CLS_CA};
      default: r = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, CLS_NONE};
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/tepf_if.sv
interface tepf_in_if #(
  parameter int unsigned IDX_BITS  = 12,
  parameter int unsigned NODE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [IDX_BITS-1:0]  tri_index;
  logic [NODE_BITS-1:0] node_a;
  logic [NODE_BITS-1:0] node_b;
  logic [NODE_BITS-1:0] node_c;

  modport source (output valid, op, tri_index, node_a, node_b, node_c, input ready);
  modport sink (input valid, op, tri_index, node_a, node_b, node_c, output ready);
endinterface

interface tepf_out_if #(
  parameter int unsigned IDX_BITS  = 12,
  parameter int unsigned NODE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic                 overflow;
  logic [13:0]          pair_number;
  logic [IDX_BITS-1:0]  first_triangle;
  logic [IDX_BITS-1:0]  second_triangle;
  logic [NODE_BITS-1:0] pair_node0;
  logic [NODE_BITS-1:0] pair_node1;
  logic [NODE_BITS-1:0] pair_node2;
  logic [NODE_BITS-1:0] pair_node3;
  logic                 last_result;

  modport source (output valid, found, overflow, pair_number, first_triangle,
                  second_triangle, pair_node0, pair_node1, pair_node2, pair_node3,
                  last_result, input ready);
  modport sink (input valid, found, overflow, pair_number, first_triangle,
                second_triangle, pair_node0, pair_node1, pair_node2, pair_node3,
                last_result, output ready);
endinterface

### hw/rtl/triangle_edge_pair_finder.sv
// Load: taken in one cycle while idle, no result.
// Query i: read of i, then each later triangle j < limit in turn through the
// 18-cell test chain, one j in the chain at a time; the final word comes after
// the scan ends and may be held up by output stalls.
// One query at a time; input ready again once the final word has left and the drain state ends.
// rst (synchronous) clears the pair counter and the register; store undefined until written.
module triangle_edge_pair_finder #(
  parameter int unsigned MAX_TRIANGLES       = 4096,
  parameter int unsigned NODE_BITS           = 16,
  parameter int unsigned MAX_PAIRS_PER_QUERY = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  tepf_in_if.sink     in_ch,
  tepf_out_if.source  out_ch
);
  localparam int unsigned IDX_BITS = 12;
  localparam int unsigned AW       = $clog2(MAX_TRIANGLES);
  localparam int unsigned CW       = AW + 1;
  localparam int unsigned PW       = $clog2(MAX_PAIRS_PER_QUERY + 1);
  localparam int unsigned DEPTH    = tepf_pkg::NUM_TESTS;
  localparam int unsigned TW       = 3 * NODE_BITS;
  localparam int unsigned FW       = $clog2(DEPTH + 3);

  typedef enum logic [2:0] {
    S_IDLE, S_RDI, S_GETI, S_SCAN, S_DRAIN, S_FINAL, S_OVF
  } state_t;

  logic [TW-1:0] store [MAX_TRIANGLES];

  logic [12:0]        num_triangles;
  state_t             state;
  logic [CW-1:0]      limit;
  logic [CW-1:0]      jcnt;
  logic [IDX_BITS-1:0] qi;
  logic [TW-1:0]      tri_i;
  logic [TW-1:0]      rd_data;
  logic               rd_valid;
  logic [IDX_BITS-1:0] rd_j;
  logic [PW-1:0]      count;
  logic [FW-1:0]      inflight;
  logic [13:0]        pair_counter;
  logic               stop;
  logic [IDX_BITS-1:0] ovf_j;

  logic                 ch_valid;
  logic [IDX_BITS-1:0]  ch_j;
  tepf_pkg::edge_cls_t  ch_cls;
  logic [NODE_BITS-1:0] ch_fourth;

  // result held until the next neighbor or scan end decides last_result
  logic                 held;
  logic [IDX_BITS-1:0]  held_j;
  tepf_pkg::edge_cls_t  held_cls;
  logic [NODE_BITS-1:0] held_fourth;
  logic [NODE_BITS-1:0] pn0, pn1, pn2;

  logic [CW-1:0] eff_limit;
  logic          in_fire, out_fire;
  logic          hit;
  logic          issue;
  logic          scan_done;

  function automatic logic [NODE_BITS-1:0] nd(input logic [TW-1:0] t, input int k);
    return t[k*NODE_BITS +: NODE_BITS];
  endfunction

  assign eff_limit = (32'(num_triangles) > MAX_TRIANGLES) ? CW'(MAX_TRIANGLES)
                                                          : CW'(num_triangles);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign hit   = ch_valid && (ch_cls != tepf_pkg::CLS_NONE) && !stop;
  // one j in the chain at a time; a hit may need the output register
  assign issue = (state == S_SCAN) && (jcnt < limit) && !out_ch.valid
                 && !stop && (inflight == '0);
  assign scan_done = (jcnt >= limit) && (inflight == '0) && !rd_valid && !ch_valid;

  always_comb begin
    case (held_cls)
      tepf_pkg::CLS_AB: begin
        pn0 = nd(tri_i, 2);
        pn1 = nd(tri_i, 0);
        pn2 = nd(tri_i, 1);
      end
      tepf_pkg::CLS_BC: begin
        pn0 = nd(tri_i, 0);
        pn1 = nd(tri_i, 2);
        pn2 = nd(tri_i, 1);
      end
      default: begin
        pn0 = nd(tri_i, 1);
        pn1 = nd(tri_i, 2);
        pn2 = nd(tri_i, 0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.op == tepf_pkg::OP_LOAD && 32'(in_ch.tri_index) < MAX_TRIANGLES) begin
      store[AW'(in_ch.tri_index)] <= {in_ch.node_c, in_ch.node_b, in_ch.node_a};
    end
    rd_data <= store[(state == S_RDI) ? AW'(qi) : AW'(jcnt)];
  end

  tepf_chain #(.NODE_BITS(NODE_BITS), .IDX_BITS(IDX_BITS)) u_chain (
    .clk(clk), .rst(rst),
    .in_valid(rd_valid), .in_j(rd_j), .in_tri_i(tri_i), .in_tri_j(rd_data),
    .out_valid(ch_valid), .out_j(ch_j), .out_cls(ch_cls), .out_fourth(ch_fourth)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      num_triangles <= '0;
      pair_counter  <= '0;
      rd_valid      <= 1'b0;
      out_ch.valid  <= 1'b0;
      held          <= 1'b0;
      stop          <= 1'b0;
      count         <= '0;
      inflight      <= '0;
    end else begin
      if (cfg_we) num_triangles <= cfg_wdata;
      if (out_fire) out_ch.valid <= 1'b0;
      rd_valid <= issue;
      rd_j     <= IDX_BITS'(jcnt);
      if (issue) jcnt <= jcnt + CW'(1);
      if (issue && !(ch_valid)) inflight <= inflight + FW'(1);
      else if (!issue && ch_valid) inflight <= inflight - FW'(1);
      case (state)
        S_IDLE: begin
          if (in_fire && in_ch.op == tepf_pkg::OP_QUERY) begin
            qi    <= in_ch.tri_index;
            limit <= eff_limit;
            jcnt  <= CW'(in_ch.tri_index) + CW'(1);
            count <= '0;
            stop  <= 1'b0;
            held  <= 1'b0;
            if (32'(in_ch.tri_index) >= 32'(eff_limit)) begin
              state <= S_FINAL;
            end else begin
              state <= S_RDI;
            end
          end
        end
        S_RDI:  state <= S_GETI;
        S_GETI: begin
          tri_i <= rd_data;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            if (held) begin
              out_ch.valid           <= 1'b1;
              out_ch.found           <= 1'b1;
              out_ch.overflow        <= 1'b0;
              out_ch.pair_number     <= pair_counter;
              out_ch.first_triangle  <= qi;
              out_ch.second_triangle <= held_j;
              out_ch.pair_node0      <= pn0;
              out_ch.pair_node1      <= pn1;
              out_ch.pair_node2      <= pn2;
              out_ch.pair_node3      <= held_fourth;
              out_ch.last_result     <= 1'b0;
              pair_counter           <= pair_counter + 14'd1;
            end
            if (count == PW'(MAX_PAIRS_PER_QUERY)) begin
              stop  <= 1'b1;
              held  <= 1'b0;
              ovf_j <= ch_j;
              state <= S_OVF;
            end else begin
              held        <= 1'b1;
              held_j      <= ch_j;
              held_cls    <= ch_cls;
              held_fourth <= ch_fourth;
              count       <= count + PW'(1);
            end
          end else if (scan_done && !out_ch.valid) begin
            if (held) begin
              out_ch.valid           <= 1'b1;
              out_ch.found           <= 1'b1;
              out_ch.overflow        <= 1'b0;
              out_ch.pair_number     <= pair_counter;
              out_ch.first_triangle  <= qi;
              out_ch.second_triangle <= held_j;
              out_ch.pair_node0      <= pn0;
              out_ch.pair_node1      <= pn1;
              out_ch.pair_node2      <= pn2;
              out_ch.pair_node3      <= held_fourth;
              out_ch.last_result     <= 1'b1;
              pair_counter           <= pair_counter + 14'd1;
              held                   <= 1'b0;
              state                  <= S_DRAIN;
            end else begin
              state <= S_FINAL;
            end
          end
        end
        S_OVF: begin
          if (!out_ch.valid) begin
            out_ch.valid           <= 1'b1;
            out_ch.found           <= 1'b0;
            out_ch.overflow        <= 1'b1;
            out_ch.pair_number     <= '0;
            out_ch.first_triangle  <= qi;
            out_ch.second_triangle <= ovf_j;
            out_ch.pair_node0      <= '0;
            out_ch.pair_node1      <= '0;
            out_ch.pair_node2      <= '0;
            out_ch.pair_node3      <= '0;
            out_ch.last_result     <= 1'b1;
            state                  <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if ((inflight == '0) && !rd_valid && !out_ch.valid) state <= S_IDLE;
        end
        S_FINAL: begin
          if (!out_ch.valid) begin
            out_ch.valid          <= 1'b1;
            out_ch.found          <= 1'b0;
            out_ch.overflow       <= 1'b0;
            out_ch.pair_number    <= '0;
            out_ch.first_triangle <= qi;
            out_ch.second_triangle <= '0;
            out_ch.pair_node0     <= '0;
            out_ch.pair_node1     <= '0;
            out_ch.pair_node2     <= '0;
            out_ch.pair_node3     <= '0;
            out_ch.last_result    <= 1'b1;
            state                 <= S_DRAIN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid || out_ch.last_result)
    else $error("input taken while a non-final word waits");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PW'(MAX_PAIRS_PER_QUERY))
    else $error("pair count past limit");
  a_found_ovf: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.found && out_ch.overflow))
    else $error("found and overflow together");
  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.overflow) |-> out_ch.last_result)
    else $error("overflow word not final");
endmodule

### hw/rtl/tepf_cell.sv
// One stage of the test chain: evaluates one shared-edge test and passes
// the running class and fourth node to its neighbor.
module tepf_cell #(
  parameter int unsigned NODE_BITS = 16,
  parameter logic [4:0]  TEST_ID   = 5'd0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [3*NODE_BITS-1:0]   in_tri_i,
  input  logic [3*NODE_BITS-1:0]   in_tri_j,
  input  tepf_pkg::edge_cls_t      in_cls,
  input  logic [NODE_BITS-1:0]     in_fourth,
  output logic                     out_valid,
  output logic [3*NODE_BITS-1:0]   out_tri_i,
  output logic [3*NODE_BITS-1:0]   out_tri_j,
  output tepf_pkg::edge_cls_t      out_cls,
  output logic [NODE_BITS-1:0]     out_fourth
);
  localparam tepf_pkg::edge_test_t T = tepf_pkg::test_of(TEST_ID);

  logic [NODE_BITS-1:0] ti [3];
  logic [NODE_BITS-1:0] tj [3];
  logic                 hit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ti[k] = in_tri_i[k*NODE_BITS +: NODE_BITS];
      tj[k] = in_tri_j[k*NODE_BITS +: NODE_BITS];
    end
    hit = (tj[T.s1] == ti[T.n1]) && (tj[T.s2] == ti[T.n2]) && (tj[T.d] != ti[T.m]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_tri_i  <= in_tri_i;
    out_tri_j  <= in_tri_j;
    out_cls    <= hit ? T.cls : in_cls;
    out_fourth <= hit ? tj[T.d] : in_fourth;
  end
endmodule

### hw/rtl/tepf_chain.sv
// Row of cells, one per test in order; the last hit wins. Also carries j.
module tepf_chain #(
  parameter int unsigned NODE_BITS = 16,
  parameter int unsigned IDX_BITS  = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [IDX_BITS-1:0]    in_j,
  input  logic [3*NODE_BITS-1:0] in_tri_i,
  input  logic [3*NODE_BITS-1:0] in_tri_j,
  output logic                   out_valid,
  output logic [IDX_BITS-1:0]    out_j,
  output tepf_pkg::edge_cls_t    out_cls,
  output logic [NODE_BITS-1:0]   out_fourth
);
  localparam int unsigned N = tepf_pkg::NUM_TESTS;

  logic                 v   [N+1];
  logic [3*NODE_BITS-1:0] ti [N+1];
  logic [3*NODE_BITS-1:0] tj [N+1];
  tepf_pkg::edge_cls_t  cl  [N+1];
  logic [NODE_BITS-1:0] fo  [N+1];
  logic [IDX_BITS-1:0]  jd  [N+1];

  assign v[0]  = in_valid;
  assign ti[0] = in_tri_i;
  assign tj[0] = in_tri_j;
  assign cl[0] = tepf_pkg::CLS_NONE;
  assign fo[0] = '0;
  assign jd[0] = in_j;

  for (genvar g = 0; g < N; g++) begin : g_cell
    tepf_cell #(.NODE_BITS(NODE_BITS), .TEST_ID(5'(g))) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(v[g]), .in_tri_i(ti[g]), .in_tri_j(tj[g]),
      .in_cls(cl[g]), .in_fourth(fo[g]),
      .out_valid(v[g+1]), .out_tri_i(ti[g+1]), .out_tri_j(tj[g+1]),
      .out_cls(cl[g+1]), .out_fourth(fo[g+1])
    );
    always_ff @(posedge clk) begin
      jd[g+1] <= jd[g];
    end
  end

  assign out_valid  = v[N];
  assign out_cls    = cl[N];
  assign out_fourth = fo[N];
  assign out_j      = jd[N];
endmodule
